FILE: rtl/toeq_pkg.sv
// Shared types and constants for the time-ordered event queue.
package toeq_pkg;

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Request payload
	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        event_time;
		logic signed [15:0] event_qty;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [31:0]        head_time;
		logic signed [15:0] head_qty;
		logic               is_empty;
		logic [1:0]         status;
	} rsp_t;

	// One stored event
	typedef struct packed {
		logic        vld;
		logic [31:0] slot_time;
		logic [15:0] slot_qty;
	} entry_t;

	// Operation broadcast to every cell in the chain
	typedef struct packed {
		logic        ins;
		logic        rem;
		logic [31:0] new_time;
		logic [15:0] new_qty;
	} cell_op_t;

endpackage

FILE: rtl/toeq_cell.sv
// One cell of the sorted chain: holds one event and shifts toward either neighbor.
module toeq_cell
	import toeq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_op_t op,
	input  entry_t   left_entry,
	input  logic     left_keep,
	input  entry_t   right_entry,
	output entry_t   entry,
	output logic     keep,
	output entry_t   entry_next
);

	entry_t entry_q;

	// A cell keeps its event on insert when that event is strictly earlier
	assign keep = entry_q.vld && (entry_q.slot_time < op.new_time);

	// Next content: hold, take the new event, or shift from a neighbor
	always_comb begin
		entry_next = entry_q;
		if (op.ins) begin
			if (!keep) begin
				if (left_keep) begin
					entry_next.vld       = 1'b1;
					entry_next.slot_time = op.new_time;
					entry_next.slot_qty  = op.new_qty;
				end else begin
					entry_next = left_entry;
				end
			end
		end else if (op.rem) begin
			entry_next = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_next;
		end
	end

	assign entry = entry_q;

endmodule

FILE: rtl/time_ordered_event_queue.sv
// Top level of the time-ordered event queue: cell chain, command decode, response register.
// A sorted queue of up to DEPTH events held in a chain of DEPTH cells, earliest at
// cell 0; every cell compares the incoming time at once, so one request is taken
// per cycle, and its response is presented in the response register on the
// following cycle. A request is held off only while an earlier response waits
// under rsp_stall. Equal times place the newest event first. Inserting into a
// full queue and removing from an empty one leave the queue untouched and are
// flagged in status. Storage scales linearly with DEPTH; the queue is empty
// after reset.
module time_ordered_event_queue
	import toeq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	entry_t   cell_entry [DEPTH];
	entry_t   cell_next  [DEPTH];
	logic     cell_keep  [DEPTH];
	cell_op_t op;
	logic     accept;
	logic     full;
	logic     empty;
	logic     drop_full;
	logic     drop_empty;
	logic [1:0] status;
	rsp_t     rsp_q;
	logic     rsp_valid_q;

	// Handshake: take a request unless a response is waiting
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	// Command decode and guard cases
	assign full       = cell_entry[DEPTH-1].vld;
	assign empty      = !cell_entry[0].vld;
	assign drop_full  = (req.cmd == CMD_INSERT) && full;
	assign drop_empty = (req.cmd == CMD_REMOVE) && empty;

	always_comb begin
		op          = '0;
		op.new_time = req.event_time;
		op.new_qty  = req.event_qty;
		op.ins      = accept && (req.cmd == CMD_INSERT) && !full;
		op.rem      = accept && (req.cmd == CMD_REMOVE) && !empty;
		if (drop_full) begin
			status = ST_FULL;
		end else if (drop_empty) begin
			status = ST_EMPTY;
		end else begin
			status = ST_OK;
		end
	end

	// Chain of cells, earliest event at cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_k = cell_keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		toeq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.left_entry (left_e),
			.left_keep  (left_k),
			.right_entry(right_e),
			.entry      (cell_entry[i]),
			.keep       (cell_keep[i]),
			.entry_next (cell_next[i])
		);
	end

	// Response register: head after the step, zero when empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (accept) begin
			rsp_valid_q        <= 1'b1;
			rsp_q.is_empty     <= !cell_next[0].vld;
			rsp_q.head_time    <= cell_next[0].vld ? cell_next[0].slot_time : 32'd0;
			rsp_q.head_qty     <= cell_next[0].vld ? cell_next[0].slot_qty : 16'sd0;
			rsp_q.status       <= status;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_full_flag : assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == CMD_INSERT) && full |=> rsp_q.status == ST_FULL)
		else $error("insert into full queue not flagged");

	a_empty_zero : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.is_empty |-> (rsp_q.head_time == 32'd0) && (rsp_q.head_qty == 16'sd0))
		else $error("empty response carries nonzero head");

	a_empty_match : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !$past(accept) |-> rsp_q.is_empty == !cell_entry[0].vld)
		else $error("empty flag disagrees with head cell");

	a_prefix : assert property (@(posedge clk) disable iff (!arst_n)
		cell_entry[1].vld |-> cell_entry[0].vld)
		else $error("hole at head of chain");

endmodule
